### rtl/core/pasg_pkg.sv
// ----------------------------------------------------------------------------
// pasg_pkg
// Shared constants, types and the sine polynomial table of the sine NCO.
// ----------------------------------------------------------------------------
`default_nettype none

package pasg_pkg;

  localparam int PHASE_BITS_DEF  = 32;
  localparam int SAMPLE_BITS_DEF = 16;

  // phase is aligned to this width before the quadrant split
  localparam int ALIGN_W  = 48;
  localparam int Q_FRAC   = 30;
  localparam int TERM_W   = Q_FRAC + 1;
  localparam int PROD_W   = 2 * TERM_W;
  localparam int T_W      = PROD_W - Q_FRAC;
  localparam int NUM_COEF = 7;
  localparam int NUM_CELLS = NUM_COEF - 1;

  localparam logic [TERM_W-1:0] Q30_ONE = TERM_W'(1) << Q_FRAC;

  // Q30 odd-power coefficients of sin(pi/2 * x)
  localparam logic [TERM_W-1:0] SINE_COEF [NUM_COEF] = '{
    31'd1686629713, 31'd693598668, 31'd85569306, 31'd5026995,
    31'd172272, 31'd3864, 31'd61
  };

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  typedef enum logic [0:0] {
    REG_PHASE_STEP  = 1'b0,
    REG_START_PHASE = 1'b1
  } pasg_reg_t;

  typedef struct packed {
    logic [1:0]        quad;
    logic [TERM_W-1:0] x;
    logic [TERM_W-1:0] z;
    logic [TERM_W-1:0] r;
  } pasg_term_t;

endpackage

`default_nettype wire

### rtl/core/pasg_in_if.sv
// ----------------------------------------------------------------------------
// pasg_in_if
// Request channel into the NCO: one sample request with a restart flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface pasg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

`default_nettype wire

### rtl/core/pasg_out_if.sv
// ----------------------------------------------------------------------------
// pasg_out_if
// Result channel of the NCO: one signed sine sample per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface pasg_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

### rtl/core/pasg_cfg_regs.sv
// ----------------------------------------------------------------------------
// pasg_cfg_regs
// APB register file: phase step and start phase.
// ----------------------------------------------------------------------------
`default_nettype none

module pasg_cfg_regs #(
  parameter int PHASE_BITS = pasg_pkg::PHASE_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pasg_pkg::CFG_AW-1:0] paddr,
  input  wire logic [pasg_pkg::CFG_DW-1:0] pwdata,
  output logic      [pasg_pkg::CFG_DW-1:0] prdata,
  output logic                             pready,
  output logic      [PHASE_BITS-1:0]       phase_step,
  output logic      [PHASE_BITS-1:0]       start_phase
);
  import pasg_pkg::*;

  logic [PHASE_BITS-1:0] step_r, step_nxt;
  logic [PHASE_BITS-1:0] start_r, start_nxt;
  pasg_reg_t             sel;
  logic                  wr;

  assign sel    = pasg_reg_t'(paddr[2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    step_nxt  = step_r;
    start_nxt = start_r;
    prdata    = '0;
    unique case (sel)
      REG_PHASE_STEP: begin
        prdata = CFG_DW'(step_r);
        if (wr) begin
          step_nxt = PHASE_BITS'(pwdata);
        end
      end
      REG_START_PHASE: begin
        prdata = CFG_DW'(start_r);
        if (wr) begin
          start_nxt = PHASE_BITS'(pwdata);
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      start_r <= '0;
    end else begin
      step_r  <= step_nxt;
      start_r <= start_nxt;
    end
  end

  assign phase_step  = step_r;
  assign start_phase = start_r;

endmodule

`default_nettype wire

### rtl/core/pasg_phase_acc.sv
// ----------------------------------------------------------------------------
// pasg_phase_acc
// Phase accumulator, quadrant fold and square stage feeding the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

module pasg_phase_acc #(
  parameter int PHASE_BITS = pasg_pkg::PHASE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  pasg_in_if.sink                     in_req,
  input  wire logic [PHASE_BITS-1:0]  phase_step,
  input  wire logic [PHASE_BITS-1:0]  start_phase,
  output logic                        v_o,
  output pasg_pkg::pasg_term_t        term_o,
  input  wire logic                   go_i
);
  import pasg_pkg::*;

  logic [PHASE_BITS-1:0] phase_r;
  logic [PHASE_BITS-1:0] cur;
  logic [ALIGN_W-1:0]    p48;
  logic [TERM_W-1:0]     x_raw;
  logic                  accept;
  logic                  go_a, go_b;
  logic                  va_r, vb_r;
  logic [1:0]            quad_a_r;
  logic [TERM_W-1:0]     xa_r;
  logic [TERM_W-1:0]     xa_nxt;
  logic [PROD_W-1:0]     sq;
  pasg_term_t            tb_r;

  assign go_b         = !vb_r || go_i;
  assign go_a         = !va_r || go_b;
  assign in_req.ready = go_a;
  assign accept       = in_req.valid && go_a;

  assign cur    = in_req.restart ? start_phase : phase_r;
  assign p48    = ALIGN_W'(cur) << (ALIGN_W - PHASE_BITS);
  assign x_raw  = {1'b0, p48[ALIGN_W-3 -: Q_FRAC]};
  assign xa_nxt = p48[ALIGN_W-2] ? (Q30_ONE - x_raw) : x_raw;
  assign sq     = {{TERM_W{1'b0}}, xa_r} * {{TERM_W{1'b0}}, xa_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      va_r    <= 1'b0;
      vb_r    <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= cur + phase_step;
      end
      if (go_a) begin
        va_r <= in_req.valid;
      end
      if (go_b) begin
        vb_r <= va_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      quad_a_r <= p48[ALIGN_W-1 -: 2];
      xa_r     <= xa_nxt;
    end
    if (go_b && va_r) begin
      tb_r.quad <= quad_a_r;
      tb_r.x    <= xa_r;
      tb_r.z    <= sq[Q_FRAC +: TERM_W];
      tb_r.r    <= SINE_COEF[NUM_COEF-1];
    end
  end

  assign v_o    = vb_r;
  assign term_o = tb_r;

  a_restart_load: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && accept && in_req.restart
      |=> phase_r == PHASE_BITS'($past(start_phase + phase_step)))
    else $error("phase not reloaded on restart");

  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !accept |=> $stable(phase_r))
    else $error("phase moved without a request");

  a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
    va_r |-> xa_r <= Q30_ONE)
    else $error("folded phase out of range");

endmodule

`default_nettype wire

### rtl/core/pasg_cell.sv
// ----------------------------------------------------------------------------
// pasg_cell
// One Horner step of the sine polynomial: r = C[K] - ((r*z) >> 30), clamped at zero.
// ----------------------------------------------------------------------------
`default_nettype none

module pasg_cell #(
  parameter int K = 0
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  v_i,
  input  wire pasg_pkg::pasg_term_t  term_i,
  output logic                       go_o,
  output logic                       v_o,
  output pasg_pkg::pasg_term_t       term_o,
  input  wire logic                  go_i
);
  import pasg_pkg::*;

  localparam logic [T_W-1:0] CK = T_W'(SINE_COEF[K]);

  logic              v_r;
  pasg_term_t        term_r;
  logic [PROD_W-1:0] prod;
  logic [T_W-1:0]    t;
  logic [TERM_W-1:0] r_nxt;

  assign go_o  = !v_r || go_i;
  assign prod  = {{TERM_W{1'b0}}, term_i.r} * {{TERM_W{1'b0}}, term_i.z};
  assign t     = prod[PROD_W-1:Q_FRAC];
  assign r_nxt = (t < CK) ? TERM_W'(CK - t) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (go_o) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (go_o && v_i) begin
      term_r.quad <= term_i.quad;
      term_r.x    <= term_i.x;
      term_r.z    <= term_i.z;
      term_r.r    <= r_nxt;
    end
  end

  assign v_o    = v_r;
  assign term_o = term_r;

  a_coef_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r |-> term_r.r <= SINE_COEF[K])
    else $error("Horner term above its coefficient");

endmodule

`default_nettype wire

### rtl/core/pasg_sine_out.sv
// ----------------------------------------------------------------------------
// pasg_sine_out
// Final odd-power multiply, rounding, saturation, sign and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pasg_sine_out #(
  parameter int SAMPLE_BITS = pasg_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  v_i,
  input  wire pasg_pkg::pasg_term_t  term_i,
  output logic                       go_o,
  pasg_out_if.source                 out_req
);
  import pasg_pkg::*;

  localparam int               MAG_W   = SAMPLE_BITS + 1;
  localparam logic [T_W-1:0]   RND     = T_W'(1) << (Q_FRAC - SAMPLE_BITS);
  localparam logic [MAG_W-1:0] MAG_MAX = (MAG_W'(1) << (SAMPLE_BITS - 1)) - MAG_W'(1);
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

  logic                   vs_r, vo_r;
  logic                   go_s;
  logic [PROD_W-1:0]      prod;
  logic [TERM_W-1:0]      s_r;
  logic                   neg_r;
  logic [T_W-1:0]         sum;
  logic [MAG_W-1:0]       mag;
  logic [SAMPLE_BITS-1:0] mag_sat;
  logic [SAMPLE_BITS-1:0] sample_nxt;
  logic [SAMPLE_BITS-1:0] sample_r;

  assign go_s = !vo_r || out_req.ready;
  assign go_o = !vs_r || go_s;
  assign prod = {{TERM_W{1'b0}}, term_i.r} * {{TERM_W{1'b0}}, term_i.x};

  assign sum        = T_W'(s_r) + RND;
  assign mag        = sum[T_W-1 -: MAG_W];
  assign mag_sat    = (mag > MAG_MAX) ? SAMPLE_BITS'(MAG_MAX) : SAMPLE_BITS'(mag);
  assign sample_nxt = neg_r ? (SAMPLE_BITS'(0) - mag_sat) : mag_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (go_o) begin
        vs_r <= v_i;
      end
      if (go_s) begin
        vo_r <= vs_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go_o && v_i) begin
      s_r   <= prod[Q_FRAC +: TERM_W];
      neg_r <= term_i.quad[1];
    end
    if (go_s && vs_r) begin
      sample_r <= sample_nxt;
    end
  end

  assign out_req.valid  = vo_r;
  assign out_req.sample = sample_r;

  a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
    vo_r |-> sample_r != SAMPLE_MIN)
    else $error("sample outside symmetric range");

endmodule

`default_nettype wire

### rtl/core/phase_accumulator_sine_gen.sv
// ----------------------------------------------------------------------------
// phase_accumulator_sine_gen
// Sine NCO: phase accumulator with a row of Horner cells for the sine.
// ----------------------------------------------------------------------------
// A request passes the fold and square stages, the six Horner cells and the
// product and sample registers of the output stage. Throughput: one request
// per cycle unless out_req stalls; each stage holds one request at a time.
// Reset (rst_n low, synchronous): phase, phase step and start phase clear
// to zero and the pipeline empties.
`default_nettype none

module phase_accumulator_sine_gen #(
  parameter int PHASE_BITS  = pasg_pkg::PHASE_BITS_DEF,
  parameter int SAMPLE_BITS = pasg_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  pasg_in_if.sink                          in_req,
  pasg_out_if.source                       out_req,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [pasg_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [pasg_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic      [pasg_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                             cfg_pready
);
  import pasg_pkg::*;

  logic [PHASE_BITS-1:0] phase_step;
  logic [PHASE_BITS-1:0] start_phase;
  logic                  v   [NUM_CELLS+1];
  pasg_term_t            term[NUM_CELLS+1];
  logic                  go  [NUM_CELLS+1];

  pasg_cfg_regs #(
    .PHASE_BITS (PHASE_BITS)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (cfg_psel),
    .penable     (cfg_penable),
    .pwrite      (cfg_pwrite),
    .paddr       (cfg_paddr),
    .pwdata      (cfg_pwdata),
    .prdata      (cfg_prdata),
    .pready      (cfg_pready),
    .phase_step  (phase_step),
    .start_phase (start_phase)
  );

  pasg_phase_acc #(
    .PHASE_BITS (PHASE_BITS)
  ) u_acc (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (in_req),
    .phase_step  (phase_step),
    .start_phase (start_phase),
    .v_o         (v[0]),
    .term_o      (term[0]),
    .go_i        (go[0])
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    pasg_cell #(
      .K (NUM_CELLS - 1 - i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .v_i    (v[i]),
      .term_i (term[i]),
      .go_o   (go[i]),
      .v_o    (v[i+1]),
      .term_o (term[i+1]),
      .go_i   (go[i+1])
    );
  end

  pasg_sine_out #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .v_i     (v[NUM_CELLS]),
    .term_i  (term[NUM_CELLS]),
    .go_o    (go[NUM_CELLS]),
    .out_req (out_req)
  );

endmodule

`default_nettype wire
